// ----- hdl/dfa_string_acceptor_core_macros.svh -----
// assertion macros shared by the acceptor rtl
`ifndef DFA_STRING_ACCEPTOR_CORE_MACROS_SVH
`define DFA_STRING_ACCEPTOR_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DSA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfa acceptor assertion failed");

// next-cycle implication, checked out of reset
`define DSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfa acceptor assertion failed");

`endif

// ----- hdl/dfa_sacc_pkg.sv -----
// shared constants, codes and types of the dfa string acceptor
`timescale 1ns / 1ps

package dfa_sacc_pkg;

   localparam int MAX_STATES  = 16;
   localparam int MAX_SYMBOLS = 16;

   localparam int STATE_W = $clog2(MAX_STATES);
   localparam int COL_W   = $clog2(MAX_SYMBOLS);
   localparam int CHAR_W  = 8;
   localparam int ALPHA_W = 5;
   localparam int CMD_W   = 2;
   localparam int TT_ADDR_W = STATE_W + COL_W;

   // item commands
   localparam logic [CMD_W-1:0] CMD_WRITE_SYMBOL     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_TRANSITION = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FEED_CHAR        = 2'd2;
   localparam logic [CMD_W-1:0] CMD_END_STRING       = 2'd3;

   // csr map, one 32-bit register per word
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_SEL_W  = 2;
   localparam logic [REG_SEL_W-1:0] REG_ALPHABET_SIZE = 2'd0;
   localparam logic [REG_SEL_W-1:0] REG_START_STATE   = 2'd1;
   localparam logic [REG_SEL_W-1:0] REG_ACCEPT_MASK   = 2'd2;

   // alphabet slot write
   typedef struct packed {
      logic              en;
      logic [COL_W-1:0]  index;
      logic [CHAR_W-1:0] value;
   } sym_write_type;

   // first matching alphabet column
   typedef struct packed {
      logic             found;
      logic [COL_W-1:0] column;
   } match_type;

endpackage

// ----- hdl/dfa_sacc_symbol_match.sv -----
// alphabet store and first-match symbol lookup
`timescale 1ns / 1ps

module dfa_sacc_symbol_match (
   input  logic                                 clock,
   input  dfa_sacc_pkg::sym_write_type          sym_wr,
   input  logic [dfa_sacc_pkg::ALPHA_W-1:0]     alphabet_size,
   input  logic [dfa_sacc_pkg::CHAR_W-1:0]      character,
   output dfa_sacc_pkg::match_type              match
);

   logic [dfa_sacc_pkg::CHAR_W-1:0]      sym_ff [dfa_sacc_pkg::MAX_SYMBOLS];
   logic [dfa_sacc_pkg::MAX_SYMBOLS-1:0] hit;

   // no reset: slots are undefined until loaded
   always_ff @(posedge clock) begin
      if (sym_wr.en) begin
         sym_ff[sym_wr.index] <= sym_wr.value;
      end
   end

   // slot in use and equal, all slots in parallel
   always_comb begin
      for (int i = 0; i < dfa_sacc_pkg::MAX_SYMBOLS; i++) begin
         hit[i] = (dfa_sacc_pkg::ALPHA_W'(i) < alphabet_size) && (sym_ff[i] == character);
      end
   end

   // lowest slot wins
   always_comb begin
      match.found  = |hit;
      match.column = '0;
      for (int i = dfa_sacc_pkg::MAX_SYMBOLS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            match.column = dfa_sacc_pkg::COL_W'(i);
         end
      end
   end

endmodule

// ----- hdl/dfa_string_acceptor_core.sv -----
// top level of the table-driven dfa string acceptor
`timescale 1ns / 1ps
// usage:
//   req channel carries one command per transfer: write an alphabet slot, write a
//   transition, feed a character or end the string (command in req_tuser)
//   rsp channel carries one verdict per end-of-string transfer, nothing for others
//   csr port (apb style, pready tied high) holds alphabet_size, start_state and
//   accept_mask at byte addresses 0, 4 and 8; write them only while the block is idle
// flow: items execute in the input register; verdicts pass to the output register
// throughput: one item per cycle, character after character, unless an end of
//   string waits for the output register; the state loop runs through the 16
//   alphabet compares, the first-match encoder and one read of the 256-entry
//   transition memory, whose registered read data is the next state
// reset: automaton returns to state 0 with the reject flag clear, registers go to
//   alphabet_size 1, start_state 0, accept_mask 0; alphabet and transition tables
//   keep whatever they hold and must be loaded before use
// stall: a held verdict does not block loads or characters; only an end of string
//   waits in the input register until the output register can take its verdict

module dfa_string_acceptor_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [3:0] entry_index, [7:4] symbol_slot, [15:8] character, [19:16] target_state
   input  logic [23:0]                            req_tdata,
   // [1:0] command
   input  logic [dfa_sacc_pkg::CMD_W-1:0]         req_tuser,
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [0] accepted, [1] bad_symbol, [5:2] final_state
   output logic [7:0]                             rsp_tdata,
   // configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [dfa_sacc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dfa_sacc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dfa_sacc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

`include "dfa_string_acceptor_core_macros.svh"

   localparam int SW = dfa_sacc_pkg::STATE_W;
   localparam int CW = dfa_sacc_pkg::COL_W;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [dfa_sacc_pkg::ALPHA_W-1:0]   alphabet_size_ff;
   logic [SW-1:0]                      start_state_ff;
   logic [dfa_sacc_pkg::MAX_STATES-1:0] accept_mask_ff;
   logic                               csr_write;
   logic [dfa_sacc_pkg::REG_SEL_W-1:0] csr_sel;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel    = csr_paddr[dfa_sacc_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         alphabet_size_ff <= dfa_sacc_pkg::ALPHA_W'(1);
         start_state_ff   <= '0;
         accept_mask_ff   <= '0;
      end else if (csr_write) begin
         case (csr_sel)
            dfa_sacc_pkg::REG_ALPHABET_SIZE: begin
               alphabet_size_ff <= csr_pwdata[dfa_sacc_pkg::ALPHA_W-1:0];
            end
            dfa_sacc_pkg::REG_START_STATE: begin
               start_state_ff <= csr_pwdata[SW-1:0];
            end
            dfa_sacc_pkg::REG_ACCEPT_MASK: begin
               accept_mask_ff <= csr_pwdata[dfa_sacc_pkg::MAX_STATES-1:0];
            end
            default: begin
               // unmapped word, write dropped
            end
         endcase
      end
   end

   // read mux
   always_comb begin
      case (csr_sel)
         dfa_sacc_pkg::REG_ALPHABET_SIZE: begin
            csr_prdata = dfa_sacc_pkg::CSR_DATA_W'(alphabet_size_ff);
         end
         dfa_sacc_pkg::REG_START_STATE: begin
            csr_prdata = dfa_sacc_pkg::CSR_DATA_W'(start_state_ff);
         end
         dfa_sacc_pkg::REG_ACCEPT_MASK: begin
            csr_prdata = dfa_sacc_pkg::CSR_DATA_W'(accept_mask_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------
   logic                             s1_valid_ff, s1_valid_in;
   logic [dfa_sacc_pkg::CMD_W-1:0]   s1_cmd_ff;
   logic [3:0]                       s1_idx_ff;
   logic [3:0]                       s1_slot_ff;
   logic [dfa_sacc_pkg::CHAR_W-1:0]  s1_char_ff;
   logic [3:0]                       s1_tgt_ff;

   logic out_free;      // output register empty or being drained
   logic s1_go;         // item in the input register executes this cycle
   logic req_fire;

   assign out_free   = ~rsp_tvalid | rsp_tready;
   // only an end of string needs room downstream
   assign s1_go      = s1_valid_ff &
                       ((s1_cmd_ff != dfa_sacc_pkg::CMD_END_STRING) | out_free);
   assign req_tready = ~s1_valid_ff | s1_go;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= req_tuser;
         s1_idx_ff  <= req_tdata[3:0];
         s1_slot_ff <= req_tdata[7:4];
         s1_char_ff <= req_tdata[15:8];
         s1_tgt_ff  <= req_tdata[19:16];
      end
   end

   // ---------------------------------------------------------------
   // alphabet lookup
   // ---------------------------------------------------------------
   dfa_sacc_pkg::sym_write_type sym_wr;
   dfa_sacc_pkg::match_type     match;

   assign sym_wr.en    = s1_go & (s1_cmd_ff == dfa_sacc_pkg::CMD_WRITE_SYMBOL);
   assign sym_wr.index = s1_idx_ff[CW-1:0];
   assign sym_wr.value = s1_char_ff;

   dfa_sacc_symbol_match u_symbol_match (
      .clock         (clock),
      .sym_wr        (sym_wr),
      .alphabet_size (alphabet_size_ff),
      .character     (s1_char_ff),
      .match         (match)
   );

   // ---------------------------------------------------------------
   // automaton state and transition memory
   // ---------------------------------------------------------------
   // the current state is either the held state or, right after a taken
   // transition, the registered memory read data
   logic [SW-1:0] state_ff, state_in;
   logic          use_rd_ff, use_rd_in;
   logic          reject_ff, reject_in;
   logic [SW-1:0] rd_data_ff;
   logic [SW-1:0] cur_state;

   logic [SW-1:0] tt_mem [dfa_sacc_pkg::MAX_STATES * dfa_sacc_pkg::MAX_SYMBOLS];
   logic                                tt_wr_en;
   logic [dfa_sacc_pkg::TT_ADDR_W-1:0]  tt_wr_addr;
   logic [dfa_sacc_pkg::TT_ADDR_W-1:0]  tt_rd_addr;

   logic is_feed;
   logic feed_step;     // character found, take the transition
   logic miss_step;     // character not in the alphabet
   logic end_step;

   assign cur_state = use_rd_ff ? rd_data_ff : state_ff;

   assign is_feed   = s1_go & (s1_cmd_ff == dfa_sacc_pkg::CMD_FEED_CHAR) & ~reject_ff;
   assign feed_step = is_feed & match.found;
   assign miss_step = is_feed & ~match.found;
   assign end_step  = s1_go & (s1_cmd_ff == dfa_sacc_pkg::CMD_END_STRING);

   assign tt_wr_en   = s1_go & (s1_cmd_ff == dfa_sacc_pkg::CMD_WRITE_TRANSITION);
   assign tt_wr_addr = {s1_idx_ff[SW-1:0], s1_slot_ff[CW-1:0]};
   assign tt_rd_addr = {cur_state, match.column};

   always_ff @(posedge clock) begin
      if (tt_wr_en) begin
         tt_mem[tt_wr_addr] <= s1_tgt_ff[SW-1:0];
      end
   end

   // read only on a taken transition so the data holds as the state
   always_ff @(posedge clock) begin
      if (feed_step) begin
         rd_data_ff <= tt_mem[tt_rd_addr];
      end
   end

   always_comb begin
      state_in  = cur_state;
      use_rd_in = feed_step;
      reject_in = reject_ff;
      if (end_step) begin
         state_in  = start_state_ff;
         reject_in = 1'b0;
      end else if (miss_step) begin
         reject_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         use_rd_ff <= 1'b0;
         reject_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         use_rd_ff <= use_rd_in;
         reject_ff <= reject_in;
      end
   end

   // ---------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_accepted_ff;
   logic          rsp_bad_ff;
   logic [SW-1:0] rsp_state_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = end_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // verdict is taken before the state returns to start
   always_ff @(posedge clock) begin
      if (end_step) begin
         rsp_accepted_ff <= ~reject_ff & accept_mask_ff[cur_state];
         rsp_bad_ff      <= reject_ff;
         rsp_state_ff    <= cur_state;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_state_ff, rsp_bad_ff, rsp_accepted_ff};

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   `DSA_ASSERT_NEXT(a_read_data_follows_step, clock, reset, feed_step, use_rd_ff)
   `DSA_ASSERT_IMPL(a_no_step_after_reject, clock, reset, reject_ff, !feed_step)
   `DSA_ASSERT_NEXT(a_end_gives_verdict, clock, reset, end_step, rsp_valid_ff)
   `DSA_ASSERT_NEXT(a_end_clears_reject, clock, reset, end_step, !reject_ff && !use_rd_ff)

endmodule
